>>> design/lsps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Lamp and switch pin scanner package
// Shared constants, codes and the per-channel state record.
// ----------------------------------------------------------------------------
package lsps_pkg;

	localparam int MAX_CHANNELS = 32;
	localparam int DEF_NUM_CHANNELS = 8;
	localparam int OUT_BITS = 8;
	localparam int COUNT_W = 8;
	localparam int MODES_W = 16;
	localparam int PERIOD_W = 8;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd100;

	typedef logic [1:0] mode_t;

	localparam mode_t MODE_INDEP = 2'd0;
	localparam mode_t MODE_MOM = 2'd1;
	localparam mode_t MODE_LAT = 2'd2;
	localparam mode_t MODE_IDLE = 2'd3;

	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_FORCE = 1'b1;

	localparam logic CFG_MODES = 1'b0;
	localparam logic CFG_PERIOD = 1'b1;

	typedef struct packed {
		logic [COUNT_W-1:0] tick_count;
		logic lamp_on;
		logic physical_on;
		logic logical_on;
		logic press_blocked;
	} lsps_chan_t;

endpackage
`default_nettype wire

>>> design/lsps_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Scanner cell
// Holds the state of one channel and takes its neighbour's record on a shift.
// ----------------------------------------------------------------------------
module lsps_cell
	import lsps_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       shift,
	input  wire lsps_chan_t chan_in,
	output lsps_chan_t      chan_out
);

	lsps_chan_t chan_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q <= '0;
		end else if (shift) begin
			chan_q <= chan_in;
		end
	end

	assign chan_out = chan_q;

endmodule
`default_nettype wire

>>> design/lsps_chan_update.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Channel update unit
// Applies one tick scan or one lamp force to the record of a single channel.
// ----------------------------------------------------------------------------
module lsps_chan_update
	import lsps_pkg::*;
(
	input  wire lsps_chan_t       chan_in,
	input  wire mode_t            mode,
	input  wire logic             level,
	input  wire logic [PERIOD_W-1:0] period,
	input  wire logic             req,
	input  wire logic             force_hit,
	input  wire logic             force_value,
	output lsps_chan_t            chan_out,
	output logic                  sampled
);

	logic                take;
	logic [COUNT_W-1:0]  count;
	lsps_chan_t          nxt;

	always_comb begin
		nxt = chan_in;
		take = 1'b0;
		count = chan_in.tick_count;
		if (mode != MODE_IDLE) begin
			if (req == REQ_FORCE) begin
				if (force_hit && mode == MODE_INDEP) begin
					nxt.lamp_on = force_value;
				end
			end else begin
				if (!chan_in.lamp_on) begin
					take = (chan_in.tick_count == COUNT_W'(1));
				end else begin
					take = (chan_in.tick_count == period);
					if (take) begin
						count = '0;
					end
				end
				if (take) begin
					nxt.physical_on = level;
				end
				unique case (mode)
					MODE_INDEP: begin
						nxt.logical_on = nxt.physical_on;
					end
					MODE_MOM: begin
						if (take) begin
							nxt.lamp_on = nxt.physical_on;
						end
						nxt.logical_on = nxt.physical_on;
					end
					default: begin
						if (nxt.physical_on) begin
							if (!chan_in.press_blocked) begin
								nxt.logical_on = !chan_in.logical_on;
								nxt.press_blocked = 1'b1;
							end
						end else begin
							nxt.press_blocked = 1'b0;
						end
						nxt.lamp_on = nxt.logical_on;
					end
				endcase
				nxt.tick_count = count + COUNT_W'(1);
			end
		end
	end

	assign chan_out = nxt;
	assign sampled = take;

endmodule
`default_nettype wire

>>> design/lamp_switch_pin_scanner.sv
`default_nettype none
// An accepted beat is registered and starts a scan pass; the finish state then loads
// the result register, and waits while a full result register is stalled.
// No new beat is accepted until the block is back in idle. The channel records
// circulate once round a ring of cells past one update unit, one channel per cycle.
// Reset clears all channel state, sets every mode to independent and the lit
// sample period to 100; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Lamp and switch pin scanner
// Scans channels whose lamp and switch share a pin, and forces single lamps in independent mode.
// ----------------------------------------------------------------------------
module lamp_switch_pin_scanner
	import lsps_pkg::*;
#(
	parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic                cfg_index,
	input  wire logic [MODES_W-1:0]  cfg_data,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic                req_type,
	input  wire logic [OUT_BITS-1:0] pin_levels,
	input  wire logic [2:0]          force_channel,
	input  wire logic                force_value,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [OUT_BITS-1:0]      lamp_levels,
	output logic [OUT_BITS-1:0]      switch_states,
	output logic [OUT_BITS-1:0]      sampled_mask
);

	localparam int STEP_W = $clog2(MAX_CHANNELS);
	localparam int OUT_N = (NUM_CHANNELS < OUT_BITS) ? NUM_CHANNELS : OUT_BITS;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FINISH = 2'd2;

	logic [1:0]           state_q;
	logic [STEP_W-1:0]    step_q;
	logic [MODES_W-1:0]   modes_q;
	logic [PERIOD_W-1:0]  period_q;
	logic                 req_q;
	logic [OUT_BITS-1:0]  pins_q;
	logic [2:0]           force_ch_q;
	logic                 force_val_q;
	logic [OUT_BITS-1:0]  smask_q;
	logic                 out_valid_q;
	logic [OUT_BITS-1:0]  lamp_q;
	logic [OUT_BITS-1:0]  switch_q;
	logic [OUT_BITS-1:0]  mask_q;

	lsps_chan_t           cell_q [NUM_CHANNELS];
	lsps_chan_t           upd_chan;
	logic                 upd_sampled;
	mode_t                cur_mode;
	logic [MODES_W-1:0]   modes_sh;
	logic [OUT_BITS-1:0]  pins_sh;
	logic                 shift;
	logic                 in_take;
	logic                 out_take;
	logic                 out_load;
	logic [OUT_BITS-1:0]  lamp_bits;
	logic [OUT_BITS-1:0]  switch_bits;

	assign cfg_ready = 1'b1;
	assign in_stall = (state_q != ST_IDLE);
	assign in_take = in_valid && !in_stall;
	assign out_take = out_valid_q && !out_stall;
	assign shift = (state_q == ST_SCAN);
	assign out_load = (state_q == ST_FINISH) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modes_q <= '0;
			period_q <= PERIOD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MODES: modes_q <= cfg_data;
				CFG_PERIOD: period_q <= cfg_data[PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			req_q <= req_type;
			pins_q <= pin_levels;
			force_ch_q <= force_channel;
			force_val_q <= force_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			smask_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						state_q <= ST_SCAN;
						step_q <= '0;
						smask_q <= '0;
					end
				end
				ST_SCAN: begin
					smask_q <= smask_q | (OUT_BITS'(upd_sampled) << step_q);
					if (step_q == STEP_W'(NUM_CHANNELS - 1)) begin
						state_q <= ST_FINISH;
						step_q <= '0;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				ST_FINISH: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign modes_sh = modes_q >> {step_q, 1'b0};
	assign pins_sh = pins_q >> step_q;
	assign cur_mode = (step_q < STEP_W'(OUT_BITS)) ? modes_sh[1:0] : MODE_IDLE;

	lsps_chan_update u_update (
		.chan_in     (cell_q[0]),
		.mode        (cur_mode),
		.level       (pins_sh[0]),
		.period      (period_q),
		.req         (req_q),
		.force_hit   (STEP_W'(force_ch_q) == step_q),
		.force_value (force_val_q),
		.chan_out    (upd_chan),
		.sampled     (upd_sampled)
	);

	for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_cell
		if (i == NUM_CHANNELS - 1) begin : g_tail
			lsps_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift    (shift),
				.chan_in  (upd_chan),
				.chan_out (cell_q[i])
			);
		end else begin : g_body
			lsps_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift    (shift),
				.chan_in  (cell_q[i+1]),
				.chan_out (cell_q[i])
			);
		end
	end

	always_comb begin
		lamp_bits = '0;
		switch_bits = '0;
		for (int c = 0; c < OUT_N; c++) begin
			lamp_bits[c] = cell_q[c].lamp_on;
			switch_bits[c] = cell_q[c].logical_on;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			lamp_q <= lamp_bits;
			switch_q <= switch_bits;
			mask_q <= (req_q == REQ_FORCE) ? '0 : smask_q;
		end
	end

	assign out_valid = out_valid_q;
	assign lamp_levels = lamp_q;
	assign switch_states = switch_q;
	assign sampled_mask = mask_q;

	assert property (@(posedge clk) disable iff (!arst_n) in_take |=> state_q == ST_SCAN)
		else $error("scan pass did not start after an accepted beat");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_SCAN |-> step_q == '0)
		else $error("channel step not at rest outside a scan pass");

	assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= STEP_W'(NUM_CHANNELS - 1))
		else $error("channel step beyond the last channel");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_load && req_q == REQ_FORCE |=> sampled_mask == '0)
		else $error("force result reports sampled channels");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall && state_q == ST_FINISH |=> state_q == ST_FINISH)
		else $error("finished pass dropped while the result register was full");

endmodule
`default_nettype wire
